// ===== rtl/pisc_pkg.sv =====
// ----------------------------------------------------------------------------
// pisc_pkg
// Types, constants and the control store of the PI speed controller.
// ----------------------------------------------------------------------------
package pisc_pkg;

	localparam int SPEED_FRAC_BITS = 8;
	localparam int GAIN_FRAC_BITS  = 8;
	localparam int DUTY_FRAC_BITS  = 16;
	localparam int EFF_SHIFT       = GAIN_FRAC_BITS + SPEED_FRAC_BITS;

	localparam int SPEED_W   = 24;
	localparam int ERR_W     = SPEED_W + 1;
	localparam int SUM_W     = SPEED_W + 2;
	localparam int INTEG_W   = 24;
	localparam int MUL_A_W   = 26;
	localparam int MUL_B_W   = 24;
	localparam int PROD_W    = MUL_A_W + MUL_B_W + 1;
	localparam int ACC_W     = PROD_W;
	localparam int DUTY_W    = 16;
	localparam int EFF_W     = 16;
	localparam int TENTHS_W  = 13;
	localparam int QUOT_W    = TENTHS_W - 1;

	localparam int GAIN_W    = 16;
	localparam int ILIM_W    = 23;
	localparam int ELIM_W    = 15;
	localparam int DSCALE_W  = 24;
	localparam int DOFF_W    = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// x / 10 == (x * RECIP10) >> RECIP_SHIFT for 0 <= x < 32768
	localparam logic [MUL_B_W-1:0] RECIP10     = 24'd52429;
	localparam int                 RECIP_SHIFT = 19;

	localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 16'd4019;
	localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST = 16'd1101;
	localparam logic [ILIM_W-1:0]   ILIM_RST       = 23'd4019;
	localparam logic [ELIM_W-1:0]   ELIM_RST       = 15'd1000;
	localparam logic [DSCALE_W-1:0] DSCALE_RST     = 24'd47186;
	localparam logic [DOFF_W-1:0]   DOFF_RST       = 16'd220;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INTEG_GAIN     = 3'd1,
		REG_INTEGRAL_LIMIT = 3'd2,
		REG_EFFORT_LIMIT   = 3'd3,
		REG_DUTY_SCALE     = 3'd4,
		REG_DUTY_OFFSET    = 3'd5
	} cfg_reg_t;

	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] PC_FIRST = 4'd1;
	localparam logic [PC_W-1:0] PC_LAST  = 4'd11;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_SUM,
		OP_CLAMP,
		OP_ACC_LOAD,
		OP_ACC_ADD,
		OP_EFF,
		OP_DIV,
		OP_ACC_OFF,
		OP_DUTY
	} uc_op_t;

	typedef enum logic [1:0] {
		A_ERR,
		A_INTEG,
		A_EFFABS,
		A_TENTHS
	} a_sel_t;

	typedef enum logic [1:0] {
		B_KP,
		B_KI,
		B_RECIP,
		B_DSCALE
	} b_sel_t;

	typedef enum logic [1:0] {
		JC_NONE,
		JC_ALWAYS,
		JC_NO_INPUT,
		JC_OUT_BUSY
	} jmp_t;

	typedef struct packed {
		uc_op_t          op;
		a_sel_t          a_sel;
		b_sel_t          b_sel;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
		logic            last;
	} uc_word_t;

	// Multiplier result is registered, so an op consumes the product issued
	// by the step before it.
	function automatic uc_word_t uc_rom(input logic [PC_W-1:0] pc);
		uc_word_t w;
		unique case (pc)
			4'd0:  w = '{OP_LOAD,     A_ERR,    B_KP,     JC_NO_INPUT, PC_IDLE, 1'b0};
			4'd1:  w = '{OP_SUM,      A_ERR,    B_KP,     JC_NONE,     PC_IDLE, 1'b0};
			4'd2:  w = '{OP_CLAMP,    A_ERR,    B_KP,     JC_NONE,     PC_IDLE, 1'b0};
			4'd3:  w = '{OP_NOP,      A_ERR,    B_KP,     JC_NONE,     PC_IDLE, 1'b0};
			4'd4:  w = '{OP_ACC_LOAD, A_INTEG,  B_KI,     JC_NONE,     PC_IDLE, 1'b0};
			4'd5:  w = '{OP_ACC_ADD,  A_ERR,    B_KP,     JC_NONE,     PC_IDLE, 1'b0};
			4'd6:  w = '{OP_EFF,      A_ERR,    B_KP,     JC_NONE,     PC_IDLE, 1'b0};
			4'd7:  w = '{OP_NOP,      A_EFFABS, B_RECIP,  JC_NONE,     PC_IDLE, 1'b0};
			4'd8:  w = '{OP_DIV,      A_ERR,    B_KP,     JC_NONE,     PC_IDLE, 1'b0};
			4'd9:  w = '{OP_NOP,      A_TENTHS, B_DSCALE, JC_NONE,     PC_IDLE, 1'b0};
			4'd10: w = '{OP_ACC_OFF,  A_ERR,    B_KP,     JC_NONE,     PC_IDLE, 1'b0};
			4'd11: w = '{OP_DUTY,     A_ERR,    B_KP,     JC_OUT_BUSY, PC_LAST, 1'b1};
			default: w = '{OP_NOP,    A_ERR,    B_KP,     JC_ALWAYS,   PC_IDLE, 1'b0};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/pisc_if.sv =====
// ----------------------------------------------------------------------------
// pisc_if
// Valid/ready channels of the PI speed controller: speed input, duty
// output and configuration write.
// ----------------------------------------------------------------------------
interface pisc_in_if;
	logic                                       valid;
	logic                                       ready;
	logic signed [pisc_pkg::SPEED_W-1:0]        set_speed;
	logic signed [pisc_pkg::SPEED_W-1:0]        measured_speed;

	modport source (output valid, output set_speed, output measured_speed, input ready);
	modport sink   (input valid, input set_speed, input measured_speed, output ready);
endinterface

interface pisc_out_if;
	logic                                valid;
	logic                                ready;
	logic        [pisc_pkg::DUTY_W-1:0]  duty;
	logic signed [pisc_pkg::EFF_W-1:0]   effort;
	logic                                integral_clamped;
	logic                                effort_saturated;

	modport source (output valid, output duty, output effort, output integral_clamped,
		output effort_saturated, input ready);
	modport sink   (input valid, input duty, input effort, input integral_clamped,
		input effort_saturated, output ready);
endinterface

interface pisc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [pisc_pkg::CFG_IDX_W-1:0]      index;
	logic [pisc_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pi_speed_controller_pwm_unit.sv =====
// ----------------------------------------------------------------------------
// pi_speed_controller_pwm_unit
// PI wheel-speed controller with integral anti-windup, effort clamp and
// PWM duty mapping, run by a microcoded sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                          transaction
//  sp_in     in   set_speed, measured_speed                        one per run
//  duty_out  out  duty, effort, integral_clamped, effort_saturated one per input
//  cfg       in   index, data                                      register write
//
//  A transaction is accepted at program step 0 and its result is registered
//  onto duty_out at the last step; the 12-step control program runs over the
//  single 26x24 multiplier, so at most one transaction is taken per run.
//  sp_in is ready only at program step 0; cfg is always ready.
//  The last step waits while an earlier result is still untaken on duty_out.
//  Reset returns the program counter to step 0, clears the integral and
//  loads the register defaults.
// ----------------------------------------------------------------------------
module pi_speed_controller_pwm_unit (
	input  logic          clk,
	input  logic          arst_n,
	pisc_in_if.sink       sp_in,
	pisc_out_if.source    duty_out,
	pisc_cfg_if.sink      cfg
);

	logic [pisc_pkg::PC_W-1:0]                pc_q;
	pisc_pkg::uc_word_t                       uc;
	logic                                     jmp_take;
	logic [pisc_pkg::PC_W-1:0]                pc_next;

	logic [pisc_pkg::GAIN_W-1:0]              prop_gain_q;
	logic [pisc_pkg::GAIN_W-1:0]              integ_gain_q;
	logic [pisc_pkg::ILIM_W-1:0]              integral_limit_q;
	logic [pisc_pkg::ELIM_W-1:0]              effort_limit_q;
	logic [pisc_pkg::DSCALE_W-1:0]            duty_scale_q;
	logic [pisc_pkg::DOFF_W-1:0]              duty_offset_q;

	logic signed [pisc_pkg::INTEG_W-1:0]      integ_q;
	logic signed [pisc_pkg::ERR_W-1:0]        err_q;
	logic signed [pisc_pkg::SUM_W-1:0]        sum_q;
	logic                                     iclamp_q;
	logic                                     esat_q;
	logic signed [pisc_pkg::ACC_W-1:0]        acc_q;
	logic signed [pisc_pkg::PROD_W-1:0]       prod_q;
	logic signed [pisc_pkg::EFF_W-1:0]        eff_q;
	logic signed [pisc_pkg::TENTHS_W-1:0]     tenths_q;

	logic                                     out_valid_q;
	logic [pisc_pkg::DUTY_W-1:0]              out_duty_q;
	logic signed [pisc_pkg::EFF_W-1:0]        out_effort_q;
	logic                                     out_iclamp_q;
	logic                                     out_esat_q;

	logic signed [pisc_pkg::MUL_A_W-1:0]      mul_a;
	logic [pisc_pkg::MUL_B_W-1:0]             mul_b;
	logic signed [pisc_pkg::PROD_W-1:0]       prod_d;
	logic [pisc_pkg::EFF_W-1:0]               eff_abs;
	logic signed [pisc_pkg::SUM_W-1:0]        ilim;
	logic signed [pisc_pkg::ACC_W-1:0]        elim_full;
	logic signed [pisc_pkg::ACC_W-1:0]        acc_rnd;
	logic signed [pisc_pkg::ACC_W-1:0]        eff_full;
	logic [pisc_pkg::QUOT_W-1:0]              quot;
	logic                                     out_load;
	logic [pisc_pkg::DUTY_W-1:0]              duty_d;
	logic                                     dsat_d;

	// ---------------- sequencer ----------------
	assign uc = pisc_pkg::uc_rom(pc_q);

	always_comb begin
		case (uc.jmp)
			pisc_pkg::JC_NONE:     jmp_take = 1'b0;
			pisc_pkg::JC_ALWAYS:   jmp_take = 1'b1;
			pisc_pkg::JC_NO_INPUT: jmp_take = !sp_in.valid;
			pisc_pkg::JC_OUT_BUSY: jmp_take = out_valid_q && !duty_out.ready;
			default:               jmp_take = 1'b1;
		endcase
		if (jmp_take) begin
			pc_next = uc.target;
		end else if (uc.last) begin
			pc_next = pisc_pkg::PC_IDLE;
		end else begin
			pc_next = pc_q + pisc_pkg::PC_W'(1);
		end
	end

	assign sp_in.ready = (uc.op == pisc_pkg::OP_LOAD);
	assign out_load    = (uc.op == pisc_pkg::OP_DUTY) && !jmp_take;
	assign cfg.ready   = 1'b1;

	// ---------------- shared multiplier ----------------
	assign eff_abs = eff_q[pisc_pkg::EFF_W-1] ? pisc_pkg::EFF_W'(-eff_q) : pisc_pkg::EFF_W'(eff_q);

	always_comb begin
		case (uc.a_sel)
			pisc_pkg::A_ERR:    mul_a = pisc_pkg::MUL_A_W'(err_q);
			pisc_pkg::A_INTEG:  mul_a = pisc_pkg::MUL_A_W'(integ_q);
			pisc_pkg::A_EFFABS: mul_a = $signed(pisc_pkg::MUL_A_W'(eff_abs));
			pisc_pkg::A_TENTHS: mul_a = pisc_pkg::MUL_A_W'(tenths_q);
			default:            mul_a = '0;
		endcase
		case (uc.b_sel)
			pisc_pkg::B_KP:     mul_b = pisc_pkg::MUL_B_W'(prop_gain_q);
			pisc_pkg::B_KI:     mul_b = pisc_pkg::MUL_B_W'(integ_gain_q);
			pisc_pkg::B_RECIP:  mul_b = pisc_pkg::RECIP10;
			pisc_pkg::B_DSCALE: mul_b = duty_scale_q;
			default:            mul_b = '0;
		endcase
	end

	assign prod_d = pisc_pkg::PROD_W'(mul_a) * $signed(pisc_pkg::PROD_W'(mul_b));

	// ---------------- datapath helpers ----------------
	assign ilim      = $signed(pisc_pkg::SUM_W'(integral_limit_q));
	assign elim_full = $signed(pisc_pkg::ACC_W'(effort_limit_q)) <<< pisc_pkg::EFF_SHIFT;
	assign acc_rnd   = acc_q[pisc_pkg::ACC_W-1]
		? acc_q + pisc_pkg::ACC_W'((64'd1 << pisc_pkg::EFF_SHIFT) - 64'd1) : acc_q;
	assign eff_full  = acc_rnd >>> pisc_pkg::EFF_SHIFT;
	assign quot      = prod_q[pisc_pkg::RECIP_SHIFT +: pisc_pkg::QUOT_W];

	// Duty truncates toward zero: a negative value above -1.0 is a plain 0.
	always_comb begin
		if (acc_q[pisc_pkg::ACC_W-1]) begin
			duty_d = '0;
			dsat_d = (acc_q <= -$signed(pisc_pkg::ACC_W'(64'd1 << pisc_pkg::DUTY_FRAC_BITS)));
		end else if (|acc_q[pisc_pkg::ACC_W-2:pisc_pkg::DUTY_FRAC_BITS+pisc_pkg::DUTY_W]) begin
			duty_d = '1;
			dsat_d = 1'b1;
		end else begin
			duty_d = acc_q[pisc_pkg::DUTY_FRAC_BITS +: pisc_pkg::DUTY_W];
			dsat_d = 1'b0;
		end
	end

	// ---------------- control and state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q             <= pisc_pkg::PC_IDLE;
			out_valid_q      <= 1'b0;
			integ_q          <= '0;
			prop_gain_q      <= pisc_pkg::PROP_GAIN_RST;
			integ_gain_q     <= pisc_pkg::INTEG_GAIN_RST;
			integral_limit_q <= pisc_pkg::ILIM_RST;
			effort_limit_q   <= pisc_pkg::ELIM_RST;
			duty_scale_q     <= pisc_pkg::DSCALE_RST;
			duty_offset_q    <= pisc_pkg::DOFF_RST;
		end else begin
			pc_q <= pc_next;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (duty_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (uc.op == pisc_pkg::OP_CLAMP) begin
				if (sum_q > ilim) begin
					integ_q <= pisc_pkg::INTEG_W'(ilim);
				end else if (sum_q < -ilim) begin
					integ_q <= pisc_pkg::INTEG_W'(-ilim);
				end else begin
					integ_q <= pisc_pkg::INTEG_W'(sum_q);
				end
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					pisc_pkg::REG_PROP_GAIN:      prop_gain_q      <= cfg.data[pisc_pkg::GAIN_W-1:0];
					pisc_pkg::REG_INTEG_GAIN:     integ_gain_q     <= cfg.data[pisc_pkg::GAIN_W-1:0];
					pisc_pkg::REG_INTEGRAL_LIMIT: integral_limit_q <= cfg.data[pisc_pkg::ILIM_W-1:0];
					pisc_pkg::REG_EFFORT_LIMIT:   effort_limit_q   <= cfg.data[pisc_pkg::ELIM_W-1:0];
					pisc_pkg::REG_DUTY_SCALE:     duty_scale_q     <= cfg.data[pisc_pkg::DSCALE_W-1:0];
					pisc_pkg::REG_DUTY_OFFSET:    duty_offset_q    <= cfg.data[pisc_pkg::DOFF_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (uc.op)
			pisc_pkg::OP_LOAD: begin
				err_q <= pisc_pkg::ERR_W'(sp_in.set_speed)
					- pisc_pkg::ERR_W'(sp_in.measured_speed);
			end
			pisc_pkg::OP_SUM: begin
				sum_q <= pisc_pkg::SUM_W'(integ_q) + pisc_pkg::SUM_W'(err_q);
			end
			pisc_pkg::OP_CLAMP: begin
				iclamp_q <= (sum_q > ilim) || (sum_q < -ilim);
			end
			pisc_pkg::OP_ACC_LOAD: begin
				acc_q <= prod_q;
			end
			pisc_pkg::OP_ACC_ADD: begin
				acc_q <= acc_q + prod_q;
			end
			pisc_pkg::OP_EFF: begin
				if (acc_q > elim_full) begin
					eff_q  <= $signed(pisc_pkg::EFF_W'(effort_limit_q));
					esat_q <= 1'b1;
				end else if (acc_q < -elim_full) begin
					eff_q  <= -$signed(pisc_pkg::EFF_W'(effort_limit_q));
					esat_q <= 1'b1;
				end else begin
					eff_q  <= pisc_pkg::EFF_W'(eff_full);
					esat_q <= 1'b0;
				end
			end
			pisc_pkg::OP_DIV: begin
				tenths_q <= eff_q[pisc_pkg::EFF_W-1]
					? -$signed(pisc_pkg::TENTHS_W'(quot)) : $signed(pisc_pkg::TENTHS_W'(quot));
			end
			pisc_pkg::OP_ACC_OFF: begin
				acc_q <= prod_q
					+ ($signed(pisc_pkg::ACC_W'(duty_offset_q)) <<< pisc_pkg::DUTY_FRAC_BITS);
			end
			default: ;
		endcase
		if (out_load) begin
			out_duty_q   <= duty_d;
			out_effort_q <= eff_q;
			out_iclamp_q <= iclamp_q;
			out_esat_q   <= esat_q || dsat_d;
		end
	end

	assign duty_out.valid            = out_valid_q;
	assign duty_out.duty             = out_duty_q;
	assign duty_out.effort           = out_effort_q;
	assign duty_out.integral_clamped = out_iclamp_q;
	assign duty_out.effort_saturated = out_esat_q;

	// ---------------- assertions ----------------
	a_accept_starts_program: assert property (@(posedge clk) disable iff (!arst_n)
		(sp_in.valid && sp_in.ready) |=> (pc_q == pisc_pkg::PC_FIRST))
		else $error("program did not advance after an input transaction");

	a_result_from_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(duty_out.valid) |-> ($past(pc_q) == pisc_pkg::PC_LAST))
		else $error("result raised outside the final program step");

	a_effort_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		duty_out.valid |->
			(($signed(duty_out.effort) <= $signed(pisc_pkg::EFF_W'(effort_limit_q)))
			&& ($signed(duty_out.effort) >= -$signed(pisc_pkg::EFF_W'(effort_limit_q)))))
		else $error("effort outside its limit");

endmodule
